// ----- sv/rcp_pkg.sv -----
// Shared types, constants and name tables for the RESP command parser.
// No dependencies; used by rcp_parser_core, rcp_out_fifo and resp_command_parser.
`timescale 1ns / 1ps

package rcp_pkg;

  typedef enum logic [3:0] {
    PH_STAR     = 4'd0,
    PH_COUNT    = 4'd1,
    PH_COUNT_LF = 4'd2,
    PH_DOLLAR   = 4'd3,
    PH_LEN      = 4'd4,
    PH_LEN_LF   = 4'd5,
    PH_FIELD    = 4'd6,
    PH_FIELD_LF = 4'd7,
    PH_SKIP     = 4'd8
  } phase_t;

  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] CMD_SET = 2'd0;
  localparam logic [1:0] CMD_GET = 2'd1;
  localparam logic [1:0] CMD_RM  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MARKER    = 3'd1;
  localparam logic [2:0] ST_LINE_END  = 3'd2;
  localparam logic [2:0] ST_COUNT     = 3'd3;
  localparam logic [2:0] ST_NUMBER    = 3'd4;
  localparam logic [2:0] ST_UNKNOWN   = 3'd5;
  localparam logic [2:0] ST_TRUNCATED = 3'd6;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] cmd;
    logic [2:0] status;
  } result_t;

  // Command name bytes; position past the name end reads as zero.
  function automatic logic [7:0] cmd_char(input logic [1:0] k, input logic [1:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      CMD_SET: begin
        case (pos)
          2'd0: c = 8'h53;
          2'd1: c = 8'h45;
          2'd2: c = 8'h54;
          default: c = 8'h00;
        endcase
      end
      CMD_GET: begin
        case (pos)
          2'd0: c = 8'h47;
          2'd1: c = 8'h45;
          2'd2: c = 8'h54;
          default: c = 8'h00;
        endcase
      end
      CMD_RM: begin
        case (pos)
          2'd0: c = 8'h52;
          2'd1: c = 8'h4D;
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] cmd_len(input logic [1:0] k);
    logic [1:0] n;
    case (k)
      CMD_SET: n = 2'd3;
      CMD_GET: n = 2'd3;
      CMD_RM:  n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- sv/rcp_parser_core.sv -----
// Parser state registers and the per-byte next-state / result logic.
// Depends on rcp_pkg.
`timescale 1ns / 1ps

module rcp_parser_core #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                res_valid,
  output rcp_pkg::result_t    res
);

  localparam int SUM_BITS = LENGTH_BITS + 4;

  rcp_pkg::phase_t        phase, phase_next;
  logic [1:0]             item_count, item_count_next;
  logic [1:0]             item_index, item_index_next;
  logic [LENGTH_BITS-1:0] number_accumulator, number_accumulator_next;
  logic                   digit_seen, digit_seen_next;
  logic [LENGTH_BITS-1:0] field_remaining, field_remaining_next;
  logic [1:0]             name_position, name_position_next;
  logic [2:0]             name_match_bits, name_match_bits_next;
  logic [1:0]             decoded_command, decoded_command_next;

  logic                   is_digit;
  logic [SUM_BITS-1:0]    num_sum;
  logic                   oversize;
  logic                   end_now;
  logic [2:0]             end_status;
  logic                   byte_now;
  logic [1:0]             byte_kind;
  logic [2:0]             final_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= rcp_pkg::PH_STAR;
      item_count         <= '0;
      item_index         <= '0;
      number_accumulator <= '0;
      digit_seen         <= 1'b0;
      field_remaining    <= '0;
      name_position      <= '0;
      name_match_bits    <= 3'b111;
      decoded_command    <= '0;
    end else if (accept) begin
      phase              <= phase_next;
      item_count         <= item_count_next;
      item_index         <= item_index_next;
      number_accumulator <= number_accumulator_next;
      digit_seen         <= digit_seen_next;
      field_remaining    <= field_remaining_next;
      name_position      <= name_position_next;
      name_match_bits    <= name_match_bits_next;
      decoded_command    <= decoded_command_next;
    end
  end

  // acc * 10 + digit as shift-add
  always_comb begin
    is_digit = (data_byte inside {[rcp_pkg::CH_0:rcp_pkg::CH_9]});
    num_sum  = {number_accumulator, 3'b000} + {2'b00, number_accumulator, 1'b0}
             + {{(SUM_BITS-4){1'b0}}, data_byte[3:0]};
    oversize = |num_sum[SUM_BITS-1:LENGTH_BITS];
  end

  always_comb begin
    phase_next              = phase;
    item_count_next         = item_count;
    item_index_next         = item_index;
    number_accumulator_next = number_accumulator;
    digit_seen_next         = digit_seen;
    field_remaining_next    = field_remaining;
    name_position_next      = name_position;
    name_match_bits_next    = name_match_bits;
    decoded_command_next    = decoded_command;
    end_now    = 1'b0;
    end_status = rcp_pkg::ST_OK;
    byte_now   = 1'b0;
    byte_kind  = rcp_pkg::KIND_KEY;
    final_match = name_match_bits;

    case (phase)
      rcp_pkg::PH_STAR, rcp_pkg::PH_DOLLAR: begin
        if (data_byte != ((phase == rcp_pkg::PH_STAR) ? rcp_pkg::CH_STAR
                                                      : rcp_pkg::CH_DOLLAR)) begin
          end_now    = 1'b1;
          end_status = rcp_pkg::ST_MARKER;
        end else begin
          number_accumulator_next = '0;
          digit_seen_next         = 1'b0;
          phase_next = (phase == rcp_pkg::PH_STAR) ? rcp_pkg::PH_COUNT : rcp_pkg::PH_LEN;
        end
      end
      rcp_pkg::PH_COUNT, rcp_pkg::PH_LEN: begin
        if (data_byte == rcp_pkg::CH_CR) begin
          if (!digit_seen) begin
            end_now    = 1'b1;
            end_status = rcp_pkg::ST_NUMBER;
          end else begin
            phase_next = (phase == rcp_pkg::PH_COUNT) ? rcp_pkg::PH_COUNT_LF
                                                      : rcp_pkg::PH_LEN_LF;
          end
        end else if (!is_digit || oversize) begin
          end_now    = 1'b1;
          end_status = rcp_pkg::ST_NUMBER;
        end else begin
          number_accumulator_next = num_sum[LENGTH_BITS-1:0];
          digit_seen_next         = 1'b1;
        end
      end
      rcp_pkg::PH_COUNT_LF: begin
        if (data_byte != rcp_pkg::CH_LF) begin
          end_now    = 1'b1;
          end_status = rcp_pkg::ST_LINE_END;
        end else if (number_accumulator != LENGTH_BITS'(2)
                     && number_accumulator != LENGTH_BITS'(3)) begin
          end_now    = 1'b1;
          end_status = rcp_pkg::ST_COUNT;
        end else begin
          item_count_next = number_accumulator[1:0];
          item_index_next = '0;
          phase_next      = rcp_pkg::PH_DOLLAR;
        end
      end
      rcp_pkg::PH_LEN_LF: begin
        if (data_byte != rcp_pkg::CH_LF) begin
          end_now    = 1'b1;
          end_status = rcp_pkg::ST_LINE_END;
        end else begin
          field_remaining_next = number_accumulator;
          name_position_next   = '0;
          name_match_bits_next = 3'b111;
          phase_next           = rcp_pkg::PH_FIELD;
        end
      end
      rcp_pkg::PH_FIELD: begin
        if (data_byte == rcp_pkg::CH_CR) begin
          phase_next = rcp_pkg::PH_FIELD_LF;
          if (item_index == 2'd0) begin
            for (int k = 0; k < 3; k++) begin
              if (name_position != rcp_pkg::cmd_len(2'(k))) final_match[k] = 1'b0;
            end
            name_match_bits_next = final_match;
            if (final_match[0])      decoded_command_next = rcp_pkg::CMD_SET;
            else if (final_match[1]) decoded_command_next = rcp_pkg::CMD_GET;
            else if (final_match[2]) decoded_command_next = rcp_pkg::CMD_RM;
            else begin
              end_now    = 1'b1;
              end_status = rcp_pkg::ST_UNKNOWN;
            end
          end
        end else if (field_remaining != '0) begin
          field_remaining_next = field_remaining - LENGTH_BITS'(1);
          if (item_index == 2'd0) begin
            for (int k = 0; k < 3; k++) begin
              if (name_position >= rcp_pkg::cmd_len(2'(k))
                  || rcp_pkg::cmd_char(2'(k), name_position) != data_byte)
                final_match[k] = 1'b0;
            end
            if (name_position < 2'd3) begin
              name_position_next   = name_position + 2'd1;
              name_match_bits_next = final_match;
            end else begin
              name_match_bits_next = 3'b000;
            end
          end else begin
            byte_now  = 1'b1;
            byte_kind = (item_index == 2'd1) ? rcp_pkg::KIND_KEY : rcp_pkg::KIND_VALUE;
          end
        end
      end
      rcp_pkg::PH_FIELD_LF: begin
        if (data_byte != rcp_pkg::CH_LF) begin
          end_now    = 1'b1;
          end_status = rcp_pkg::ST_LINE_END;
        end else begin
          item_index_next = item_index + 2'd1;
          if ((item_index + 2'd1) >= item_count) begin
            end_now    = 1'b1;
            end_status = rcp_pkg::ST_OK;
          end else begin
            phase_next = rcp_pkg::PH_DOLLAR;
          end
        end
      end
      default: ;
    endcase

    if (end_now) phase_next = rcp_pkg::PH_SKIP;

    // truncated end overrides a byte carried by the final transfer
    if (last_byte && phase_next != rcp_pkg::PH_SKIP) begin
      end_now    = 1'b1;
      end_status = rcp_pkg::ST_TRUNCATED;
    end

    res_valid = accept && (end_now || byte_now);
    if (end_now) begin
      res.kind   = rcp_pkg::KIND_END;
      res.data   = 8'h00;
      res.cmd    = decoded_command_next;
      res.status = end_status;
    end else begin
      res.kind   = byte_kind;
      res.data   = data_byte;
      res.cmd    = 2'd0;
      res.status = rcp_pkg::ST_OK;
    end

    if (last_byte) begin
      phase_next              = rcp_pkg::PH_STAR;
      item_count_next         = '0;
      item_index_next         = '0;
      number_accumulator_next = '0;
      digit_seen_next         = 1'b0;
      field_remaining_next    = '0;
      name_position_next      = '0;
      name_match_bits_next    = 3'b111;
      decoded_command_next    = '0;
    end
  end

endmodule

// ----- sv/rcp_out_fifo.sv -----
// Two-entry result buffer between the parser and the output channel.
// Depends on rcp_pkg for the result struct.
`timescale 1ns / 1ps

module rcp_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rcp_pkg::result_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output rcp_pkg::result_t head_data
);

  rcp_pkg::result_t slot [2];
  logic             head;
  logic [1:0]       count;
  logic             wr_ptr;

  assign wr_ptr    = head ^ count[0];
  assign full      = count[1];
  assign not_empty = (count != 2'd0);
  assign head_data = slot[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (pop) head <= ~head;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

endmodule

// ----- sv/resp_command_parser.sv -----
// Top level of the RESP command parser: input handshake, parser core, result buffer.
// Depends on rcp_pkg, rcp_parser_core and rcp_out_fifo.
`timescale 1ns / 1ps

// Byte-serial parser for one RESP-style request: '*' count CRLF, then 2 or 3
// items of '$' length CRLF field CRLF; the first field names SET, GET or RM.
// Input channel: data_byte/last_byte with in_valid/in_stall. One byte is
// transferred per cycle when in_valid is high and in_stall low.
// Output channel: result_kind/result_byte/command_kind/parse_status with
// out_valid/out_stall. Key and value bytes come out as they arrive; one end
// result carries the command and the status.
// A result is registered in the result buffer and shown once it reaches its head.
// Throughput: one byte per clock while in_stall is low; the byte step is a single
// pass through the parser core, and a two-entry result buffer decouples the sides.
// Stall: while the receiver stalls, results collect in the buffer; once it
// holds two, in_stall rises until one is taken.
// Reset (rst, synchronous): parser waits for '*', buffer empties.
// After last_byte the parser returns to its reset state; an unfinished
// request yields a truncated end result.
module resp_command_parser #(
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] result_kind,
  output logic [7:0] result_byte,
  output logic [1:0] command_kind,
  output logic [2:0] parse_status
);

  logic             in_accept;
  logic             res_valid;
  rcp_pkg::result_t res;
  rcp_pkg::result_t head_data;
  logic             buf_full;

  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;

  rcp_parser_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  rcp_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (out_valid && !out_stall),
    .full      (buf_full),
    .not_empty (out_valid),
    .head_data (head_data)
  );

  assign result_kind  = head_data.kind;
  assign result_byte  = head_data.data;
  assign command_kind = head_data.cmd;
  assign parse_status = head_data.status;

`ifndef SYNTHESIS
  a_stall_needs_pending: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  a_result_from_transfer: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_accept)
    else $error("result produced without an input transfer");

  a_byte_result_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind != rcp_pkg::KIND_END) |->
      (command_kind == 2'd0 && parse_status == rcp_pkg::ST_OK))
    else $error("key/value result carries command or status");

  a_end_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == rcp_pkg::KIND_END) |-> (result_byte == 8'h00))
    else $error("end result carries a data byte");
`endif

endmodule
